@@ hw/rtl/rtd_pkg.sv @@
package rtd_pkg;

  // field widths
  localparam int SAMPLE_W = 23;
  localparam int TEMP_W   = 18;
  localparam int STAT_W   = 2;
  localparam int IDX_W    = 3;
  localparam int CFG_W    = 35;

  // pipelined divider: quotient bits, divisor and partial remainder widths
  localparam int QUO_W = 63;
  localparam int DVS_W = 45;
  localparam int REM_W = DVS_W + 1;

  // pipelined square root: radicand and root widths
  localparam int RAD_W  = 72;
  localparam int ROOT_W = RAD_W / 2;

  localparam int YMAG_W = 63;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_LOW   = 2'd1,
    ST_DISC  = 2'd2,
    ST_CLAMP = 2'd3
  } status_t;

  localparam logic [IDX_W-1:0] REG_BIAS = 3'd0;
  localparam logic [IDX_W-1:0] REG_GAIN = 3'd1;
  localparam logic [IDX_W-1:0] REG_CUR  = 3'd2;
  localparam logic [IDX_W-1:0] REG_R0   = 3'd3;
  localparam logic [IDX_W-1:0] REG_LIN  = 3'd4;
  localparam logic [IDX_W-1:0] REG_SQR  = 3'd5;

  localparam logic signed [TEMP_W-1:0] TEMP_HI = 18'sd85000;
  localparam logic signed [TEMP_W-1:0] TEMP_LO = -18'sd20000;

  // uV * 1e9 * 1024 / (gain_milli * nA) gives milliohms in Q10
  localparam logic [29:0] GIGA  = 30'd1000000000;
  // 100 * 2^18
  localparam logic [24:0] SCALE = 25'd26214400;

  // per-word sideband that travels with the arithmetic
  typedef struct packed {
    logic              fin;   // status already settled
    status_t           stat;
    logic              neg;   // resistance below R0
    logic [YMAG_W-1:0] ymag;  // |x - 1| in Q23
  } side_t;

endpackage

@@ hw/rtl/rtd_in_if.sv @@
interface rtd_in_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [rtd_pkg::SAMPLE_W-1:0]     sample_microvolts;

  modport source (output valid, output sample_microvolts, input ready);
  modport sink (input valid, input sample_microvolts, output ready);
endinterface

@@ hw/rtl/rtd_out_if.sv @@
interface rtd_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [rtd_pkg::TEMP_W-1:0]   temp_centideg;
  logic [rtd_pkg::STAT_W-1:0]          status_code;

  modport source (output valid, output temp_centideg, output status_code, input ready);
  modport sink (input valid, input temp_centideg, input status_code, output ready);
endinterface

@@ hw/rtl/rtd_div.sv @@
module rtd_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [rtd_pkg::REM_W-1:0]   in_rem,
  input  logic [rtd_pkg::QUO_W-1:0]   in_num,
  input  logic [rtd_pkg::DVS_W-1:0]   in_div,
  input  rtd_pkg::side_t              in_side,
  output logic                        out_valid,
  output logic [rtd_pkg::QUO_W-1:0]   out_quo,
  output rtd_pkg::side_t              out_side
);
  import rtd_pkg::*;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] num;
    logic [QUO_W-1:0] quo;
  } dstage_t;

  dstage_t          st_r  [1:QUO_W];
  logic [DVS_W-1:0] dv_r  [1:QUO_W];
  side_t            sd_r  [1:QUO_W];
  logic [QUO_W:1]   vld_r;
  dstage_t          st_in;

  // one restoring step: shift in a dividend bit, subtract when it fits
  function automatic dstage_t div_step(dstage_t s, logic [DVS_W-1:0] dv);
    dstage_t          o;
    logic [REM_W-1:0] sh;
    logic             fit;
    sh    = {s.rem[REM_W-2:0], s.num[QUO_W-1]};
    fit   = (sh >= {1'b0, dv});
    o.rem = fit ? (sh - {1'b0, dv}) : sh;
    o.num = {s.num[QUO_W-2:0], 1'b0};
    o.quo = {s.quo[QUO_W-2:0], fit};
    return o;
  endfunction

  assign st_in = '{rem: in_rem, num: in_num, quo: '0};

  // advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[QUO_W-1:1], in_valid};
    end
  end

  // advance the stages
  always_ff @(posedge clk) begin
    if (en) begin
      st_r[1] <= div_step(st_in, in_div);
      dv_r[1] <= in_div;
      sd_r[1] <= in_side;
      for (int i = 1; i < QUO_W; i++) begin
        st_r[i+1] <= div_step(st_r[i], dv_r[i]);
        dv_r[i+1] <= dv_r[i];
        sd_r[i+1] <= sd_r[i];
      end
    end
  end

  assign out_valid = vld_r[QUO_W];
  assign out_quo   = st_r[QUO_W].quo;
  assign out_side  = sd_r[QUO_W];

endmodule

@@ hw/rtl/rtd_sqrt.sv @@
module rtd_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [rtd_pkg::RAD_W-1:0]   in_rad,
  input  rtd_pkg::side_t              in_side,
  output logic                        out_valid,
  output logic [rtd_pkg::ROOT_W-1:0]  out_root,
  output rtd_pkg::side_t              out_side
);
  import rtd_pkg::*;

  localparam int TRI_W = RAD_W + 2;

  typedef struct packed {
    logic [RAD_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sstage_t;

  sstage_t         st_r [1:ROOT_W];
  side_t           sd_r [1:ROOT_W];
  logic [ROOT_W:1] vld_r;
  sstage_t         st_in;

  // try root bit b: (r + 2^b)^2 - r^2 = r*2^(b+1) + 2^(2b)
  function automatic sstage_t sq_step(sstage_t s, int b);
    sstage_t          o;
    logic [TRI_W-1:0] trial;
    logic             fit;
    trial  = (TRI_W'(s.root) << (b + 1)) + (TRI_W'(1) << (2 * b));
    fit    = ({2'b00, s.rem} >= trial);
    o.rem  = fit ? RAD_W'({2'b00, s.rem} - trial) : s.rem;
    o.root = fit ? (s.root | (ROOT_W'(1) << b)) : s.root;
    return o;
  endfunction

  assign st_in = '{rem: in_rad, root: '0};

  // advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[ROOT_W-1:1], in_valid};
    end
  end

  // one root bit per stage, most significant first
  always_ff @(posedge clk) begin
    if (en) begin
      st_r[1] <= sq_step(st_in, ROOT_W - 1);
      sd_r[1] <= in_side;
      for (int i = 1; i < ROOT_W; i++) begin
        st_r[i+1] <= sq_step(st_r[i], ROOT_W - 1 - i);
        sd_r[i+1] <= sd_r[i];
      end
    end
  end

  assign out_valid = vld_r[ROOT_W];
  assign out_root  = st_r[ROOT_W].root;
  assign out_side  = sd_r[ROOT_W];

endmodule

@@ hw/rtl/rtd_voltage_to_temperature.sv @@
// Throughput: one sample per cycle while out_ch is not stalled; set by three 63-stage
// radix-2 dividers and a 36-stage square root, each retiring one bit per stage.
// A stall at the output freezes the whole pipeline; nothing is lost or repeated.
// Reset (rst_n low, synchronous) clears all valid bits and loads register defaults.
module rtd_voltage_to_temperature (
  input  logic                          clk,
  input  logic                          rst_n,
  rtd_in_if.sink                        in_ch,
  rtd_out_if.source                     out_ch,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rtd_pkg::IDX_W-1:0]     cfg_index,
  input  logic [rtd_pkg::CFG_W-1:0]     cfg_data
);
  import rtd_pkg::*;

  // configuration registers
  logic signed [22:0] bias_r;
  logic [19:0]        gain_r;
  logic [23:0]        cur_r;
  logic [23:0]        r0_r;
  logic [33:0]        lin_r;
  logic signed [34:0] sqr_r;

  // values derived from configuration
  logic [43:0]  gcur_r;
  logic [33:0]  dd_r;
  logic [67:0]  a2_r;
  logic [34:0]  bn;

  logic         en;

  // stage A: bias removed
  logic                a_vld_r;
  logic signed [23:0]  a_d_r;
  logic signed [23:0]  a_d_nxt;

  // stage B: dividend for the resistance
  logic         b_vld_r;
  logic [52:0]  b_prod_r;
  side_t        b_side_r;
  side_t        b_side_nxt;
  logic         b_dlow;

  // divider 1: resistance in milliohms, Q10
  logic         q1_vld;
  logic [62:0]  q1_quo;
  side_t        q1_side;

  // stage C: dividend for x - 1
  logic         c_vld_r;
  logic [85:0]  c_num_r;
  logic [85:0]  c_num_nxt;
  side_t        c_side_r;
  side_t        c_side_nxt;
  logic         c_ge;
  logic [62:0]  c_n;
  logic [33:0]  c_m;
  logic         c_ovf;

  // divider 2: |x - 1| in Q23
  logic         q2_vld;
  logic [62:0]  q2_quo;
  side_t        q2_side;

  // stage D and E: 4|B|y term
  logic         d_vld_r;
  logic [66:0]  d_plo_r;
  logic [65:0]  d_phi_r;
  side_t        d_side_r;
  logic         e_vld_r;
  logic [104:0] e_term_r;
  side_t        e_side_r;

  // stage F: discriminant
  logic         f_vld_r;
  logic [RAD_W-1:0] f_disc_r;
  logic [RAD_W-1:0] f_disc_nxt;
  side_t        f_side_r;
  side_t        f_side_nxt;
  logic [104:0] f_a2;

  // square root
  logic              s_vld;
  logic [ROOT_W-1:0] s_root;
  side_t             s_side;

  // stage G and H: rounded quotient operands
  logic         g_vld_r;
  logic [51:0]  g_num_r;
  logic [36:0]  g_den_r;
  logic [36:0]  g_den_nxt;
  side_t        g_side_r;
  side_t        g_side_nxt;
  logic         h_vld_r;
  logic [53:0]  h_dvd_r;
  logic [37:0]  h_dvs_r;
  side_t        h_side_r;

  // divider 3: temperature magnitude
  logic         q3_vld;
  logic [62:0]  q3_quo;
  side_t        q3_side;

  // output register
  logic                      out_vld_r;
  logic signed [TEMP_W-1:0]  out_temp_r;
  logic signed [TEMP_W-1:0]  out_temp_nxt;
  status_t                   out_stat_r;
  status_t                   out_stat_nxt;

  // configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_r <= '0;
      gain_r <= 20'd1000;
      cur_r  <= 24'd1000000;
      r0_r   <= 24'd100000;
      lin_r  <= 34'd4297221295;
      sqr_r  <= -35'sd2600828785;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BIAS: bias_r <= cfg_data[22:0];
        REG_GAIN: gain_r <= cfg_data[19:0];
        REG_CUR:  cur_r  <= cfg_data[23:0];
        REG_R0:   r0_r   <= cfg_data[23:0];
        REG_LIN:  lin_r  <= cfg_data[33:0];
        REG_SQR:  sqr_r  <= cfg_data[34:0];
        default: ;
      endcase
    end
  end

  // zero gain, current or R0 registers count as one
  always_ff @(posedge clk) begin
    gcur_r <= 44'((gain_r == '0) ? 20'd1 : gain_r) * 44'((cur_r == '0) ? 24'd1 : cur_r);
    dd_r   <= {((r0_r == '0) ? 24'd1 : r0_r), 10'b0};
    a2_r   <= 68'(lin_r) * 68'(lin_r);
  end

  assign bn = 35'(~sqr_r) + 35'd1;

  // whole pipeline moves when the output word can move
  assign en = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  // advance valid bits of the top-level stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r   <= 1'b0;
      b_vld_r   <= 1'b0;
      c_vld_r   <= 1'b0;
      d_vld_r   <= 1'b0;
      e_vld_r   <= 1'b0;
      f_vld_r   <= 1'b0;
      g_vld_r   <= 1'b0;
      h_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r   <= in_ch.valid;
      b_vld_r   <= a_vld_r;
      c_vld_r   <= q1_vld;
      d_vld_r   <= q2_vld;
      e_vld_r   <= d_vld_r;
      f_vld_r   <= e_vld_r;
      g_vld_r   <= s_vld;
      h_vld_r   <= g_vld_r;
      out_vld_r <= q3_vld;
    end
  end

  // stage A: subtract bias
  assign a_d_nxt = {in_ch.sample_microvolts[SAMPLE_W-1], in_ch.sample_microvolts}
                 - {bias_r[22], bias_r};

  // stage B: flag low voltage and bad coefficient sign
  always_comb begin
    b_dlow          = a_d_r[23] || (a_d_r == '0);
    b_side_nxt      = '0;
    b_side_nxt.stat = ST_OK;
    if (b_dlow) begin
      b_side_nxt.fin  = 1'b1;
      b_side_nxt.stat = ST_LOW;
    end else if (!sqr_r[34]) begin
      b_side_nxt.fin  = 1'b1;
      b_side_nxt.stat = ST_DISC;
    end
  end

  // stage C: split on R against R0, flag huge resistance
  always_comb begin
    c_ge  = (q1_quo >= 63'(dd_r));
    c_n   = q1_quo - 63'(dd_r);
    c_m   = dd_r - q1_quo[33:0];
    c_ovf = c_ge && ({11'b0, c_n} >= {dd_r, 40'b0});
    if (c_ge) begin
      c_num_nxt = {c_n, 23'b0};
    end else begin
      // round the magnitude up below R0
      c_num_nxt = 86'({c_m, 23'b0}) + 86'(dd_r) - 86'd1;
    end
    c_side_nxt     = q1_side;
    c_side_nxt.neg = !c_ge;
    if (!q1_side.fin && c_ovf) begin
      c_side_nxt.fin  = 1'b1;
      c_side_nxt.stat = ST_DISC;
    end
  end

  // stage F: discriminant and large-y clamp
  always_comb begin
    f_a2       = 105'(a2_r);
    f_side_nxt = e_side_r;
    if (!e_side_r.fin && !e_side_r.neg) begin
      if (e_term_r > f_a2) begin
        f_side_nxt.fin  = 1'b1;
        f_side_nxt.stat = ST_DISC;
      end else if (|e_side_r.ymag[62:27]) begin
        f_side_nxt.fin  = 1'b1;
        f_side_nxt.stat = ST_CLAMP;
      end
    end
    if (e_side_r.neg) begin
      f_disc_nxt = RAD_W'(f_a2 + e_term_r);
    end else begin
      f_disc_nxt = RAD_W'(f_a2 - e_term_r);
    end
  end

  // stage G: denominator A + root, zero denominator gives zero degrees
  always_comb begin
    g_den_nxt  = 37'(lin_r) + 37'(s_root);
    g_side_nxt = s_side;
    if (!s_side.fin && (g_den_nxt == '0)) begin
      g_side_nxt.fin  = 1'b1;
      g_side_nxt.stat = ST_OK;
    end
  end

  // top-level stage payloads
  always_ff @(posedge clk) begin
    if (en) begin
      a_d_r    <= a_d_nxt;
      b_prod_r <= 53'(a_d_r[22:0]) * 53'(GIGA);
      b_side_r <= b_side_nxt;
      c_num_r  <= c_num_nxt;
      c_side_r <= c_side_nxt;
      d_plo_r  <= 67'(bn) * 67'(q2_quo[31:0]);
      d_phi_r  <= 66'(bn) * 66'(q2_quo[62:32]);
      d_side_r <= '{fin: q2_side.fin, stat: q2_side.stat, neg: q2_side.neg, ymag: q2_quo};
      e_term_r <= {({d_phi_r, 32'b0} + 98'(d_plo_r)), 7'b0};
      e_side_r <= d_side_r;
      f_disc_r <= f_disc_nxt;
      f_side_r <= f_side_nxt;
      g_num_r  <= 52'(s_side.ymag[26:0]) * 52'(SCALE);
      g_den_r  <= g_den_nxt;
      g_side_r <= g_side_nxt;
      h_dvd_r  <= {1'b0, g_num_r, 1'b0} + 54'(g_den_r);
      h_dvs_r  <= {g_den_r, 1'b0};
      h_side_r <= g_side_r;
      out_temp_r <= out_temp_nxt;
      out_stat_r <= out_stat_nxt;
    end
  end

  rtd_div u_div_res (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (b_vld_r),
    .in_rem    ('0),
    .in_num    ({b_prod_r, 10'b0}),
    .in_div    (DVS_W'(gcur_r)),
    .in_side   (b_side_r),
    .out_valid (q1_vld),
    .out_quo   (q1_quo),
    .out_side  (q1_side)
  );

  rtd_div u_div_ratio (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (c_vld_r),
    .in_rem    (REM_W'(c_num_r[85:63])),
    .in_num    (c_num_r[62:0]),
    .in_div    (DVS_W'(dd_r)),
    .in_side   (c_side_r),
    .out_valid (q2_vld),
    .out_quo   (q2_quo),
    .out_side  (q2_side)
  );

  rtd_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (f_vld_r),
    .in_rad    (f_disc_r),
    .in_side   (f_side_r),
    .out_valid (s_vld),
    .out_root  (s_root),
    .out_side  (s_side)
  );

  rtd_div u_div_temp (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (h_vld_r),
    .in_rem    ('0),
    .in_num    (QUO_W'(h_dvd_r)),
    .in_div    (DVS_W'(h_dvs_r)),
    .in_side   (h_side_r),
    .out_valid (q3_vld),
    .out_quo   (q3_quo),
    .out_side  (q3_side)
  );

  // sign, clamp and settle the result word
  always_comb begin
    out_stat_nxt = ST_OK;
    out_temp_nxt = '0;
    if (q3_side.fin) begin
      out_stat_nxt = q3_side.stat;
      out_temp_nxt = (q3_side.stat == ST_CLAMP) ? TEMP_HI : '0;
    end else if (!q3_side.neg) begin
      if (q3_quo > 63'(TEMP_HI)) begin
        out_stat_nxt = ST_CLAMP;
        out_temp_nxt = TEMP_HI;
      end else begin
        out_temp_nxt = TEMP_W'(q3_quo);
      end
    end else begin
      if (q3_quo > 63'd20000) begin
        out_stat_nxt = ST_CLAMP;
        out_temp_nxt = TEMP_LO;
      end else begin
        out_temp_nxt = -TEMP_W'(q3_quo);
      end
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.temp_centideg = out_temp_r;
  assign out_ch.status_code   = out_stat_r;

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (out_stat_r == ST_LOW || out_stat_r == ST_DISC) |-> out_temp_r == '0)
    else $error("error status with nonzero temperature");

  a_clamp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (out_stat_r == ST_CLAMP) |-> (out_temp_r == TEMP_HI || out_temp_r == TEMP_LO))
    else $error("clamped word not at a span bound");

  a_ok_span: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (out_stat_r == ST_OK) |-> (out_temp_r <= TEMP_HI && out_temp_r >= TEMP_LO))
    else $error("ok word outside span");

  a_stall_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while pipeline frozen");
`endif

endmodule

@@ tb/rtd_voltage_to_temperature_test.sv @@
module rtd_voltage_to_temperature_test;
  import rtd_pkg::*;

  localparam int  LATENCY     = 234;
  localparam int  CYCLE_LIMIT = 400000;
  localparam int  NUM_REGS    = 6;
  localparam int  REG_WIDTH [NUM_REGS] = '{23, 20, 24, 24, 34, 35};

  typedef struct {
    logic signed [TEMP_W-1:0] temp;
    status_t                  stat;
  } temp_word_t;

  logic clk = 1'b0;
  logic rst_n;

  rtd_in_if  in_ch ();
  rtd_out_if out_ch ();

  logic             cfg_valid;
  logic             cfg_ready;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  rtd_voltage_to_temperature i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // shadow copy of the register file
  logic [CFG_W-1:0] shadow_regs [NUM_REGS];
  temp_word_t       pending_temps [$];

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int hold_left    = 0;
  int cycle_count  = 0;
  int mismatches   = 0;
  int unexpected   = 0;
  int words_seen   = 0;
  int samples_sent = 0;
  int cfg_writes   = 0;

  always #10 clk = ~clk;

  // stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
               pending_temps.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver: long hold-off when requested, else random stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // check every result word against the oldest prediction
  always @(posedge clk) begin
    temp_word_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      words_seen++;
      if (pending_temps.size() == 0) begin
        unexpected++;
        if (unexpected + mismatches <= 10)
          $display("unexpected word: temp %0d status %0d", out_ch.temp_centideg,
                   out_ch.status_code);
      end else begin
        want = pending_temps.pop_front();
        if (out_ch.temp_centideg !== want.temp || out_ch.status_code !== want.stat) begin
          mismatches++;
          if (unexpected + mismatches <= 10)
            $display("mismatch: expected temp %0d status %0d, got temp %0d status %0d",
                     want.temp, want.stat, out_ch.temp_centideg, out_ch.status_code);
        end
      end
    end
  end

  // predict one conversion from the shadow registers
  function automatic temp_word_t convert_sample(logic signed [SAMPLE_W-1:0] smp);
    logic signed [63:0] d, bq;
    logic [127:0] g, cur, r0, rq, dd, n, ip, m, ymag, bn, term, a, a2, disc, sq, c, den, num, q;
    logic neg;
    logic signed [63:0] t;
    temp_word_t r;
    d  = 64'(smp) - 64'($signed(shadow_regs[REG_BIAS][22:0]));
    bq = 64'($signed(shadow_regs[REG_SQR][34:0]));
    a  = 128'(shadow_regs[REG_LIN][33:0]);
    t  = 0;
    if (d <= 0) return '{18'sd0, ST_LOW};
    if (bq >= 0) return '{18'sd0, ST_DISC};
    bn  = 128'(-bq);
    g   = shadow_regs[REG_GAIN][19:0] != 0 ? 128'(shadow_regs[REG_GAIN][19:0]) : 128'd1;
    cur = shadow_regs[REG_CUR][23:0]  != 0 ? 128'(shadow_regs[REG_CUR][23:0])  : 128'd1;
    r0  = shadow_regs[REG_R0][23:0]   != 0 ? 128'(shadow_regs[REG_R0][23:0])   : 128'd1;
    rq  = (128'(d) * 128'd1024000000000) / (g * cur);
    dd  = r0 << 10;
    if (rq >= dd) begin
      n  = rq - dd;
      ip = n / dd;
      if (ip >= (128'd1 << 40)) return '{18'sd0, ST_DISC};
      ymag = (ip << 23) + (((n % dd) << 23) / dd);
      neg  = 1'b0;
    end else begin
      m    = dd - rq;
      ymag = ((m << 23) + dd - 1) / dd;
      neg  = 1'b1;
    end
    term = (bn * ymag) << 7;
    a2   = a * a;
    if (!neg) begin
      if (term > a2) return '{18'sd0, ST_DISC};
      disc = a2 - term;
      if (ymag >= (128'd1 << 27)) return '{TEMP_HI, ST_CLAMP};
    end else begin
      disc = a2 + term;
    end
    sq = 0;
    for (int b = 35; b >= 0; b--) begin
      c = sq | (128'd1 << b);
      if (c * c <= disc) sq = c;
    end
    den = a + sq;
    if (den != 0) begin
      num = ymag * 128'd26214400;
      q   = (2 * num + den) / (2 * den);
      t   = neg ? -$signed(64'(q)) : $signed(64'(q));
    end
    if (t > 85000) return '{TEMP_HI, ST_CLAMP};
    if (t < -20000) return '{TEMP_LO, ST_CLAMP};
    r.temp = TEMP_W'(t);
    r.stat = ST_OK;
    return r;
  endfunction

  // write one register, then drop valid for a cycle
  task automatic write_reg(logic [IDX_W-1:0] idx, logic [35:0] value);
    logic [35:0] masked;
    masked = value & ((36'd1 << REG_WIDTH[idx]) - 1);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_W'(masked);
    do @(posedge clk); while (!cfg_ready);
    shadow_regs[idx] = CFG_W'(masked);
    cfg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // offer one sample word, with random idle cycles ahead of it
  task automatic send_sample(logic signed [SAMPLE_W-1:0] smp);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid             <= 1'b1;
    in_ch.sample_microvolts <= smp;
    do @(posedge clk); while (!in_ch.ready);
    pending_temps.push_back(convert_sample(smp));
    samples_sent++;
  endtask

  // release the input and wait for every predicted word
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_temps.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] clip_uv(logic signed [63:0] v);
    if (v > 4096000) return 23'sd4096000;
    if (v < -4096000) return -23'sd4096000;
    return SAMPLE_W'(v);
  endfunction

  // mostly a voltage that maps to a plausible resistance, else any voltage
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    logic signed [63:0] bias, span;
    logic [127:0] prod;
    bias = 64'($signed(shadow_regs[REG_BIAS][22:0]));
    if ($urandom_range(99) < 30) return SAMPLE_W'($signed($urandom_range(8192000)) - 4096000);
    prod = 128'(shadow_regs[REG_R0][23:0]) * shadow_regs[REG_GAIN][19:0]
         * shadow_regs[REG_CUR][23:0] * $urandom_range(500, 5);
    span = 64'(prod / 128'd100000000000);
    return clip_uv(bias + span);
  endfunction

  task automatic restore_defaults();
    write_reg(REG_BIAS, 36'd0);
    write_reg(REG_GAIN, 36'd1000);
    write_reg(REG_CUR, 36'd1000000);
    write_reg(REG_R0, 36'd100000);
    write_reg(REG_LIN, 36'd4297221295);
    write_reg(REG_SQR, 36'(-64'sd2600828785));
  endtask

  task automatic randomize_regs();
    if ($urandom_range(99) < 70) begin
      write_reg(REG_BIAS, 36'($signed($urandom_range(40000)) - 20000));
      write_reg(REG_GAIN, 36'($urandom_range(5000, 500)));
      write_reg(REG_CUR, 36'($urandom_range(2000000, 100000)));
      write_reg(REG_R0, 36'($urandom_range(1000000, 50000)));
      write_reg(REG_LIN, 36'(64'd4297221295 + $signed($urandom_range(400000000)) - 200000000));
      write_reg(REG_SQR, 36'(-64'sd2600828785 + $signed($urandom_range(1000000000)) - 500000000));
    end else begin
      write_reg(REG_BIAS, 36'($signed($urandom_range(8192000)) - 4096000));
      write_reg(REG_GAIN, 36'($urandom));
      write_reg(REG_CUR, 36'($urandom));
      write_reg(REG_R0, 36'($urandom));
      write_reg(REG_LIN, 36'({$urandom, $urandom}));
      write_reg(REG_SQR, 36'({$urandom, $urandom}));
    end
  endtask

  // defaults: sample extremes, not above bias, zero degrees, tiny and huge resistance
  task automatic test_default_span();
    send_sample(-23'sd4096000);
    send_sample(23'sd0);
    send_sample(23'sd1);
    send_sample(23'sd100000);
    send_sample(23'sd100001);
    send_sample(23'sd38500);
    send_sample(23'sd175856);
    send_sample(23'sd390000);
    send_sample(23'sd4096000);
    drain_results();
  endtask

  // register corners: bias extremes, zero and large registers, coefficient signs
  task automatic test_register_corners();
    write_reg(REG_BIAS, 36'd4096000);
    send_sample(23'sd4096000);
    send_sample(-23'sd4096000);
    drain_results();
    write_reg(REG_BIAS, 36'(-64'sd4096000));
    send_sample(23'sd4096000);
    send_sample(-23'sd4095999);
    drain_results();
    write_reg(REG_GAIN, 36'd0);
    write_reg(REG_CUR, 36'd0);
    write_reg(REG_R0, 36'd0);
    send_sample(23'sd4096000);
    drain_results();
    write_reg(REG_BIAS, 36'd0);
    write_reg(REG_GAIN, 36'd1000000);
    write_reg(REG_CUR, 36'd10000000);
    write_reg(REG_R0, 36'd10000000);
    send_sample(23'sd4096000);
    drain_results();
    restore_defaults();
    write_reg(REG_SQR, 36'd5);
    send_sample(23'sd150000);
    drain_results();
    write_reg(REG_SQR, 36'd0);
    send_sample(23'sd150000);
    drain_results();
    write_reg(REG_SQR, 36'(-64'sd1));
    write_reg(REG_LIN, 36'd0);
    send_sample(23'sd150000);
    send_sample(23'sd50000);
    drain_results();
    write_reg(REG_SQR, 36'(-64'sd17179869184));
    write_reg(REG_LIN, 36'd17179869183);
    send_sample(23'sd150000);
    send_sample(23'sd50000);
    drain_results();
    restore_defaults();
  endtask

  // random phases, new settings for each but the first, cycling the idle patterns
  task automatic test_random_phases();
    for (int ph = 0; ph < 16; ph++) begin
      case (ph % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 50; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 50; end
        default: begin tx_idle_pct = 34; rx_stall_pct = 34; end
      endcase
      if (ph != 0) randomize_regs();
      repeat (80) send_sample(pick_sample());
      drain_results();
    end
  endtask

  // hold the receiver long enough that the pipeline fills and backs up the input
  task automatic test_backpressure();
    tx_idle_pct  = 0;
    rx_stall_pct = 10;
    restore_defaults();
    hold_left = 800;
    repeat (350) send_sample(pick_sample());
    drain_results();
  endtask

  // sender stops until all words are back, then resumes
  task automatic test_sender_pause();
    tx_idle_pct  = 20;
    rx_stall_pct = 20;
    randomize_regs();
    repeat (30) send_sample(pick_sample());
    drain_results();
    repeat (30) send_sample(pick_sample());
    drain_results();
    rx_stall_pct = 0;
  endtask

  initial begin
    rst_n                   = 1'b0;
    in_ch.valid             = 1'b0;
    in_ch.sample_microvolts = '0;
    out_ch.ready            = 1'b0;
    cfg_valid               = 1'b0;
    cfg_index               = '0;
    cfg_data                = '0;
    shadow_regs[REG_BIAS]   = '0;
    shadow_regs[REG_GAIN]   = 35'd1000;
    shadow_regs[REG_CUR]    = 35'd1000000;
    shadow_regs[REG_R0]     = 35'd100000;
    shadow_regs[REG_LIN]    = 35'd4297221295;
    shadow_regs[REG_SQR]    = 35'(-64'sd2600828785);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_span();
    test_register_corners();
    test_random_phases();
    test_backpressure();
    test_sender_pause();

    // flush the pipeline tail
    drain_results();
    repeat (LATENCY + 20) @(posedge clk);

    $display("covered %0d samples, %0d words checked, %0d register writes", samples_sent,
             words_seen, cfg_writes);
    $display("idle and stall mixes, long output hold-off, zero and corner registers");
    if (mismatches == 0 && unexpected == 0 && pending_temps.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches, %0d unexpected, %0d missing", mismatches, unexpected,
               pending_temps.size());
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
